// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } wsd_kind_t;

    // Error codes
    localparam logic ERR_PROTOCOL = 1'b0;   // close 1002
    localparam logic ERR_TOO_BIG  = 1'b1;   // close 1009

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header encodings
    localparam logic [6:0]  LEN7_EXT16      = 7'd126;
    localparam logic [6:0]  LEN7_EXT64      = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN    = 64'd125;
    localparam logic [3:0]  EXT16_BYTES     = 4'd2;
    localparam logic [3:0]  EXT64_BYTES     = 4'd8;
    localparam logic [3:0]  MASK_KEY_BYTES  = 4'd4;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       resync;
    } wsd_in_t;

    typedef struct packed {
        wsd_kind_t   kind;
        logic        final_fragment;
        logic [3:0]  frame_opcode;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic        error_code;
    } wsd_out_t;

    // Classified word handed from the parser to the output stage
    typedef struct packed {
        wsd_kind_t   kind;
        logic        fin;
        logic [3:0]  opcode;
        logic [31:0] length;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        last;
        logic        code;
    } wsd_entry_t;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the client WebSocket frame deframer.
`timescale 1ns / 1ps

//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data: max_payload_bytes (32 b)
//  in      | in        | in_valid / in_ready   | in_data: rx_byte, resync
//  out     | out       | out_valid / out_ready | out_data: header, payload byte, error
//
//  One input word per cycle while the queue is not full; each result is written
//  by the parser into the queue, then from the queue into the output register.
//  The parser stalls only when the 4-entry queue is full; the output stage
//  drains it whenever its register is empty or being taken.
//  Reset is asynchronous, active low: parser expects a first header byte,
//  queue is empty, max_payload_bytes returns to 65536.
//  cfg_ready is always high; write only while the block is idle.

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  wsd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output wsd_out_t    out_data
);

    logic [31:0] max_payload_bytes_reg;
    logic        in_fire;
    logic        push, pop, full, empty;
    wsd_entry_t  push_entry, head;

    // Configuration register: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_bytes_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_valid)
            max_payload_bytes_reg <= cfg_data;
    end

    // Take a byte whenever the queue has room; each byte yields at most one entry
    assign in_ready = !full;
    assign in_fire  = in_valid && in_ready;

    // Front: header and length parsing, frame checks, key lane selection
    wsd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_payload_bytes (max_payload_bytes_reg),
        .in_fire           (in_fire),
        .in_data           (in_data),
        .push              (push),
        .push_entry        (push_entry)
    );

    // Decoupling queue: lets the output side stall without stopping the parser until the queue fills
    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    // Back: unmask and hold the result word until taken
    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/wsd_front.sv =====
// Frame parser: accepts input words and classifies them into queue entries.
`timescale 1ns / 1ps

module wsd_front
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] max_payload_bytes,
    input  logic        in_fire,
    input  wsd_in_t     in_data,
    output logic        push,
    output wsd_entry_t  push_entry
);

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [3:0]  fbc_reg, fbc_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] rem_reg, rem_next;
    logic [1:0]  lane_reg, lane_next;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic        emit;
    wsd_kind_t   emit_kind;
    logic [31:0] emit_len;
    logic [7:0]  emit_raw;
    logic [7:0]  emit_key;
    logic        emit_last;
    logic        emit_code;
    logic [7:0]  lane_key;

    function automatic logic opcode_ok(input logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
               op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    function automatic logic too_big(input logic [63:0] len, input logic [31:0] lim);
        return (len[63:32] != 32'd0) || (len[31:0] > lim);
    endfunction

    assign b = in_data.rx_byte;
    assign len7 = b[6:0];

    always_comb
    begin
        case (lane_reg)
            2'd0:    lane_key = key_reg[31:24];
            2'd1:    lane_key = key_reg[23:16];
            2'd2:    lane_key = key_reg[15:8];
            default: lane_key = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_eff   = in_data.resync ? PH_HDR1 : phase_reg;
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        acc_next    = acc_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        lane_next   = lane_reg;
        emit        = 1'b0;
        emit_kind   = KIND_ERROR;
        emit_len    = 32'd0;
        emit_raw    = 8'd0;
        emit_key    = 8'd0;
        emit_last   = 1'b0;
        emit_code   = ERR_PROTOCOL;
        if (in_fire)
        begin
            phase_next = phase_eff;
            case (phase_eff)
                PH_HDR1:
                begin
                    fin_next    = b[7];
                    opcode_next = b[3:0];
                    if (b[6:4] != 3'd0 || !opcode_ok(b[3:0]))
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DROP;
                    end
                    else
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (!b[7])
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        key_next = 32'd0;
                        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                        begin
                            acc_next   = 64'd0;
                            fbc_next   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            acc_next = {57'd0, len7};
                            if (too_big({57'd0, len7}, max_payload_bytes))
                            begin
                                emit       = 1'b1;
                                emit_code  = ERR_TOO_BIG;
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                fbc_next   = MASK_KEY_BYTES;
                                phase_next = PH_MASK;
                            end
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    acc_next = {acc_reg[55:0], b};
                    fbc_next = fbc_reg - 4'd1;
                    if (fbc_next == 4'd0)
                    begin
                        if (too_big(acc_next, max_payload_bytes))
                        begin
                            emit       = 1'b1;
                            emit_code  = ERR_TOO_BIG;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            fbc_next   = MASK_KEY_BYTES;
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], b};
                    fbc_next = fbc_reg - 4'd1;
                    if (fbc_next == 4'd0)
                    begin
                        emit = 1'b1;
                        // Control frames must be unfragmented and short
                        if (opcode_reg[3] && (!fin_reg || acc_reg > CTRL_MAX_LEN))
                            phase_next = PH_DROP;
                        else
                        begin
                            rem_next   = acc_reg[31:0];
                            lane_next  = 2'd0;
                            emit_kind  = KIND_HEADER;
                            emit_len   = acc_reg[31:0];
                            emit_last  = (acc_reg[31:0] == 32'd0);
                            phase_next = (acc_reg[31:0] == 32'd0) ? PH_HDR1 : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next   = rem_reg - 32'd1;
                    lane_next  = lane_reg + 2'd1;
                    emit       = 1'b1;
                    emit_kind  = KIND_PAYLOAD;
                    emit_len   = acc_reg[31:0];
                    emit_raw   = b;
                    emit_key   = lane_key;
                    emit_last  = (rem_next == 32'd0);
                    if (rem_next == 32'd0)
                        phase_next = PH_HDR1;
                end
                default:
                    phase_next = PH_DROP;
            endcase
        end
    end

    assign push                = emit;
    assign push_entry.kind     = emit_kind;
    assign push_entry.fin      = fin_next;
    assign push_entry.opcode   = opcode_next;
    assign push_entry.length   = emit_len;
    assign push_entry.raw_byte = emit_raw;
    assign push_entry.key_byte = emit_key;
    assign push_entry.last     = emit_last;
    assign push_entry.code     = emit_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            fbc_reg    <= 4'd0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            acc_reg    <= 64'd0;
            key_reg    <= 32'd0;
            rem_reg    <= 32'd0;
            lane_reg   <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            acc_reg    <= acc_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            lane_reg   <= lane_next;
        end
    end

    // Drop everything after an error until resync
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_data.resync && phase_reg == PH_DROP) |-> !push)
        else $error("parser emitted while dropping");

    // Every error leaves the parser dropping
    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_entry.kind == KIND_ERROR) |=> phase_reg == PH_DROP)
        else $error("error did not enter drop phase");

endmodule

// ===== hw/rtl/wsd_queue.sv =====
// Short FIFO of classified entries between parser and output stage.
`timescale 1ns / 1ps

module wsd_queue
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wsd_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output wsd_entry_t  head
);

    wsd_entry_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/wsd_back.sv =====
// Output stage: unmasks payload bytes and holds the result word.
`timescale 1ns / 1ps

module wsd_back
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  wsd_entry_t  head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output wsd_out_t    out_data
);

    logic     valid_reg;
    wsd_out_t data_reg, data_next;

    assign pop = !empty && (!valid_reg || out_ready);

    always_comb
    begin
        data_next.kind           = head.kind;
        data_next.final_fragment = head.fin;
        data_next.frame_opcode   = head.opcode;
        data_next.payload_length = head.length;
        data_next.payload_byte   = head.raw_byte ^ head.key_byte;
        data_next.last_of_frame  = head.last;
        data_next.error_code     = head.code;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !pop)
        else $error("output overwritten while stalled");

endmodule

// ===== tb/sv/wsd_frame_checker.sv =====
// Predicts deframer results from the accepted bytes and compares them with the output channel.
`timescale 1ns / 1ps

module wsd_frame_checker
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  wsd_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  wsd_out_t    out_data,
    output int          fail_count,
    output int          outstanding,
    output logic        at_frame_start
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_KEY,
        PH_BODY,
        PH_DISCARD
    } parse_phase_t;

    parse_phase_t phase     = PH_FIRST;
    logic [3:0]   byte_cnt  = '0;
    logic         fin       = 1'b0;
    logic [3:0]   opc       = OP_CONT;
    logic [63:0]  len_acc   = '0;
    logic [31:0]  key       = '0;
    logic [31:0]  remaining = '0;
    logic [1:0]   lane      = '0;
    logic [31:0]  size_limit = MAX_PAYLOAD_RESET;

    wsd_out_t frame_results_q[$];
    int       mismatches = 0;

    assign fail_count     = mismatches;
    assign outstanding    = frame_results_q.size();
    assign at_frame_start = (phase == PH_FIRST);

    function automatic logic legal_opcode(input logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
               op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    task automatic push_result(input wsd_kind_t k, input logic [31:0] len,
                               input logic [7:0] data, input logic last, input logic code);
        wsd_out_t r;
        r.kind           = k;
        r.final_fragment = fin;
        r.frame_opcode   = opc;
        r.payload_length = len;
        r.payload_byte   = data;
        r.last_of_frame  = last;
        r.error_code     = code;
        frame_results_q.insert(frame_results_q.size(), r);
    endtask

    task automatic reject_frame(input logic code);
        phase = PH_DISCARD;
        push_result(KIND_ERROR, '0, '0, 1'b0, code);
    endtask

    // Length complete: check it against the limit, then collect the mask key
    task automatic close_length();
        if (len_acc > {32'd0, size_limit})
            reject_frame(ERR_TOO_BIG);
        else
        begin
            byte_cnt = MASK_KEY_BYTES;
            phase    = PH_KEY;
        end
    endtask

    task automatic parse_byte(input wsd_in_t w);
        logic [7:0] b;
        logic [6:0] len7;
        logic [7:0] key_byte;
        b = w.rx_byte;
        if (w.resync)
            phase = PH_FIRST;
        case (phase)
            PH_FIRST:
            begin
                fin = b[7];
                opc = b[3:0];
                if (b[6:4] != 3'b000 || !legal_opcode(opc))
                    reject_frame(ERR_PROTOCOL);
                else
                    phase = PH_SECOND;
            end
            PH_SECOND:
            begin
                if (!b[7])
                    reject_frame(ERR_PROTOCOL);
                else
                begin
                    len7    = b[6:0];
                    len_acc = '0;
                    key     = '0;
                    if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                    begin
                        byte_cnt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        phase    = PH_EXTLEN;
                    end
                    else
                    begin
                        len_acc = {57'd0, len7};
                        close_length();
                    end
                end
            end
            PH_EXTLEN:
            begin
                len_acc  = {len_acc[55:0], b};
                byte_cnt = byte_cnt - 4'd1;
                if (byte_cnt == 4'd0)
                    close_length();
            end
            PH_KEY:
            begin
                key      = {key[23:0], b};
                byte_cnt = byte_cnt - 4'd1;
                if (byte_cnt == 4'd0)
                begin
                    if (opc >= OP_CLOSE && (!fin || len_acc > CTRL_MAX_LEN))
                        reject_frame(ERR_PROTOCOL);
                    else
                    begin
                        remaining = len_acc[31:0];
                        lane      = '0;
                        push_result(KIND_HEADER, len_acc[31:0], '0, remaining == '0,
                                    ERR_PROTOCOL);
                        phase = (remaining == '0) ? PH_FIRST : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                key_byte  = key[8 * (3 - lane) +: 8];
                remaining = remaining - 32'd1;
                lane      = lane + 2'd1;
                push_result(KIND_PAYLOAD, len_acc[31:0], b ^ key_byte, remaining == '0,
                            ERR_PROTOCOL);
                if (remaining == '0)
                    phase = PH_FIRST;
            end
            default:
                phase = PH_DISCARD;
        endcase
    endtask

    task automatic check_result(input wsd_out_t got);
        wsd_out_t want;
        if (frame_results_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected result kind=%0d len=%0d byte=%h", $realtime,
                         got.kind, got.payload_length, got.payload_byte);
            mismatches++;
        end
        else
        begin
            want = frame_results_q.pop_front();
            if (got.kind !== want.kind || got.final_fragment !== want.final_fragment ||
                got.frame_opcode !== want.frame_opcode ||
                got.payload_length !== want.payload_length ||
                got.payload_byte !== want.payload_byte ||
                got.last_of_frame !== want.last_of_frame ||
                got.error_code !== want.error_code)
            begin
                if (mismatches < 10)
                    $display({"%0t: result mismatch\n",
                              "  expected kind=%0d fin=%b op=%h len=%0d byte=%h last=%b code=%b\n",
                              "  actual   kind=%0d fin=%b op=%h len=%0d byte=%h last=%b code=%b"},
                             $realtime,
                             want.kind, want.final_fragment, want.frame_opcode,
                             want.payload_length, want.payload_byte, want.last_of_frame,
                             want.error_code,
                             got.kind, got.final_fragment, got.frame_opcode,
                             got.payload_length, got.payload_byte, got.last_of_frame,
                             got.error_code);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase      = PH_FIRST;
            byte_cnt   = '0;
            fin        = 1'b0;
            opc        = OP_CONT;
            len_acc    = '0;
            key        = '0;
            remaining  = '0;
            lane       = '0;
            size_limit = MAX_PAYLOAD_RESET;
            frame_results_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_valid && cfg_ready)
                size_limit = cfg_data;
            if (in_valid && in_ready)
                parse_byte(in_data);
        end
    end

endmodule

// ===== tb/sv/websocket_frame_deframer_test.sv =====
// Stimulus and verdict for the WebSocket frame deframer, checked by wsd_frame_checker.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;

    import wsd_pkg::*;

    // Length field encodings a frame can be sent with
    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    localparam int RANDOM_WORDS   = 1500;
    localparam int RANDOM_PHASES  = 8;
    localparam int HOLD_CYCLES    = 300;   // long receiver stall for back-pressure
    localparam int SETTLE_CYCLES  = 8;     // settling margin after the last result
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    wsd_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    wsd_out_t    out_data;

    int   fail_count;
    int   outstanding;
    logic frame_boundary;

    // Sender and receiver pacing, changed per phase
    int          in_gap_max  = 0;
    int          out_gap_max = 0;
    logic        hold_req    = 1'b0;
    logic        stream_dirty = 1'b0;   // parser not at a frame start: resync next frame
    logic [31:0] max_now     = MAX_PAYLOAD_RESET;
    int          words_sent  = 0;
    int          idle_cycles = 0;

    websocket_frame_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    wsd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .at_frame_start (frame_boundary)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: end the run if no channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: stall a random number of cycles before each word, and hold off
    // for a long stretch when the stimulus asks, so the internal queue fills up
    initial
    begin : receiver
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready = 1'b0;
                hold_req  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one word after a random gap; keep valid high across back-to-back words
    task automatic send_word(input logic [7:0] b, input logic rs);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.rx_byte = b;
        in_data.resync  = rs;
        in_valid        = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the parser settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = '0;
        max_now   = v;
    endtask

    // Send one frame; nbytes below the length abandons it part way
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input len_form_t form,
                              input logic [63:0] len, input logic [31:0] key, input int nbytes);
        logic       rs;
        logic [6:0] len7;
        int         i;
        // Resync always after an error or an abandoned frame, sometimes otherwise
        rs = stream_dirty || ($urandom_range(0, 7) == 0);
        send_word({fin, rsv, op}, rs);
        case (form)
            LEN_EXT16: len7 = LEN7_EXT16;
            LEN_EXT64: len7 = LEN7_EXT64;
            default:   len7 = len[6:0];
        endcase
        send_word({masked, len7}, 1'b0);
        if (form == LEN_EXT16)
        begin
            send_word(len[15:8], 1'b0);
            send_word(len[7:0], 1'b0);
        end
        else if (form == LEN_EXT64)
        begin
            for (i = 7; i >= 0; i--)
                send_word(len[8 * i +: 8], 1'b0);
        end
        for (i = 3; i >= 0; i--)
            send_word(key[8 * i +: 8], 1'b0);
        for (i = 0; i < nbytes; i++)
            send_word(8'($urandom), 1'b0);
        stream_dirty = !frame_boundary;
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_word(8'($urandom), 1'b0);
        stream_dirty = !frame_boundary;
    endtask

    // Mostly well-formed frames with random content; a few broken ones
    task automatic random_frame();
        logic [3:0]  op;
        logic [2:0]  rsv;
        logic        fin;
        logic        masked;
        logic [63:0] len;
        logic [63:0] cap;
        len_form_t   form;
        int          r;
        int          nbytes;
        r = $urandom_range(0, 99);
        if (r < 80)
            op = 4'($urandom_range(OP_CONT, OP_BINARY));
        else if (r < 95)
            op = 4'($urandom_range(OP_CLOSE, OP_PONG));
        else if ($urandom_range(0, 1) == 0)
            op = 4'($urandom_range(OP_BINARY + 1, OP_CLOSE - 1));
        else
            op = 4'($urandom_range(OP_PONG + 1, 15));
        rsv    = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(1, 7)) : 3'd0;
        fin    = (op >= OP_CLOSE) ? ($urandom_range(0, 9) != 0) : 1'($urandom);
        masked = ($urandom_range(0, 99) >= 3);

        cap = (op >= OP_CLOSE) ? 64'd125 : 64'd48;
        if (cap > {32'd0, max_now})
            cap = {32'd0, max_now};
        r = $urandom_range(0, 99);
        if (r < 4 && max_now != 32'hFFFF_FFFF)
            len = {32'd0, max_now} + 64'd1;                  // just over the limit
        else if (r < 7)
            len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
        else if (r < 10 && op >= OP_CLOSE)
            len = 64'($urandom_range(126, 130));             // control frame too long
        else if (r < 14)
            len = 64'($urandom_range(0, max_now));           // anywhere up to the limit
        else
            len = 64'($urandom_range(0, 32'(cap)));

        // Cut off long payloads early; abandon some frames part way
        nbytes = (len <= 64'd130) ? int'(len) : $urandom_range(0, 8);
        if (nbytes > 0 && $urandom_range(0, 19) == 0)
            nbytes = $urandom_range(0, nbytes - 1);

        r = $urandom_range(0, 99);
        if (len < 64'd126)
            form = (r < 80) ? LEN_SHORT : ((r < 90) ? LEN_EXT16 : LEN_EXT64);
        else if (len < 64'd65536)
            form = (r < 85) ? LEN_EXT16 : LEN_EXT64;
        else
            form = LEN_EXT64;

        if ($urandom_range(0, 19) == 0)
            send_noise($urandom_range(1, 4));
        send_frame(fin, rsv, op, masked, form, len, $urandom, nbytes);
    endtask

    initial
    begin : stimulus
        logic [31:0] phase_limits [RANDOM_PHASES];
        int          p;
        int          base_words;
        phase_limits = '{32'hFFFF_FFFF, 32'd0, 32'd125, 32'd126,
                         32'd65535, 32'd1000, 32'd30, MAX_PAYLOAD_RESET};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames under the reset limit
        in_gap_max  = 3;
        out_gap_max = 3;
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_SHORT, 64'd0, $urandom, 0);
        send_frame(1'b0, 3'd0, OP_BINARY, 1'b1, LEN_SHORT, 64'd3, 32'hFFFF_FFFF, 3);
        send_frame(1'b1, 3'd0, OP_CONT, 1'b1, LEN_EXT16, 64'd5, 32'h0000_0000, 5);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_EXT64, 64'd6, $urandom, 6);
        send_frame(1'b1, 3'd0, OP_PING, 1'b1, LEN_SHORT, 64'd125, $urandom, 125);
        send_frame(1'b1, 3'd0, OP_PONG, 1'b1, LEN_SHORT, 64'd0, $urandom, 0);
        send_frame(1'b1, 3'd0, OP_CLOSE, 1'b1, LEN_SHORT, 64'd2, $urandom, 2);
        // Reserved bits set, then bytes dropped until resync
        send_frame(1'b1, 3'b111, OP_TEXT, 1'b1, LEN_SHORT, 64'd1, $urandom, 1);
        send_noise(3);
        // Unknown opcode, unmasked frame
        send_frame(1'b1, 3'd0, OP_BINARY + 4'd1, 1'b1, LEN_SHORT, 64'd0, $urandom, 0);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, LEN_SHORT, 64'd4, $urandom, 0);
        // Over the length limit, including the all-ones 64-bit length
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_EXT64, 64'd65537, $urandom, 0);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_EXT64, '1, $urandom, 0);
        // Fragmented control frame, control frame over 125 bytes
        send_frame(1'b0, 3'd0, OP_PING, 1'b1, LEN_SHORT, 64'd1, $urandom, 1);
        send_frame(1'b1, 3'd0, OP_CLOSE, 1'b1, LEN_EXT16, 64'd126, $urandom, 0);
        // Abandon a frame mid-payload
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_SHORT, 64'd10, $urandom, 3);

        // Limit of zero: only empty frames pass
        wait_idle();
        write_limit(32'd0);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_SHORT, 64'd0, $urandom, 0);
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_SHORT, 64'd1, $urandom, 1);

        // Largest limit: full 32-bit length accepted, one more is too big
        wait_idle();
        write_limit(32'hFFFF_FFFF);
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, LEN_EXT64, 64'hFFFF_FFFF, $urandom, 4);
        send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, LEN_EXT64, 64'h1_0000_0000, $urandom, 0);
        wait_idle();

        // Random phases, each with its own limit and pacing
        base_words = words_sent;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_limit(phase_limits[p]);
            in_gap_max  = (p % 2 == 1) ? 12 : 0;
            out_gap_max = (p % 4 >= 2) ? 12 : 0;
            if (p == 0)
            begin
                // Hold off the receiver while a long frame streams in back to back
                hold_req = 1'b1;
                send_frame(1'b1, 3'd0, OP_TEXT, 1'b1, LEN_SHORT, 64'd100, $urandom, 100);
            end
            while (words_sent < base_words + RANDOM_WORDS * (p + 1) / RANDOM_PHASES)
                random_frame();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer.sv
tb/sv/wsd_frame_checker.sv
tb/sv/websocket_frame_deframer_test.sv
